>>> src/vnoise2d_pkg.sv
package vnoise2d_pkg;

  localparam int COORD_W             = 32;
  localparam int VALUE_W             = 32;
  localparam int Q_BITS              = 30;
  localparam int COORD_FRAC_BITS_DEF = 16;
  localparam int NUM_STAGES          = 11;
  localparam int NUM_CORNERS         = 4;

  // Lattice corner lanes
  localparam int C00 = 0;
  localparam int C10 = 1;
  localparam int C01 = 2;
  localparam int C11 = 3;

  // Integer hash constants
  localparam logic [31:0] HASH_ROW_MUL = 32'd57;
  localparam int          HASH_SHIFT   = 13;
  localparam logic [31:0] HASH_C1      = 32'd15731;
  localparam logic [31:0] HASH_C2      = 32'd789221;
  localparam logic [31:0] HASH_C3      = 32'd1376312589;

  localparam logic [31:0] ONE_Q30   = 32'h4000_0000;
  localparam logic [31:0] THREE_Q30 = 32'hC000_0000;
  localparam logic [63:0] HALF_Q30  = 64'h0000_0000_2000_0000;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [VALUE_W-1:0] value_t;

endpackage

>>> src/value_noise_2d_bilinear.sv
// 2D value noise with smoothstep-shaped bilinear interpolation.
// Throughput: one item per cycle unless every stage is full and out_stall_i is high;
// each of the 11 register stages holds one item and carries its own valid bit, so
// bubbles are squeezed out under stall.
// Reset (rst_ni low, asynchronous) clears all valid bits; no payload is reset.
module value_noise_2d_bilinear #(
  parameter int COORD_FRAC_BITS = vnoise2d_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  vnoise2d_pkg::coord_t  coord_x_i,
  input  vnoise2d_pkg::coord_t  coord_y_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output vnoise2d_pkg::value_t  noise_value_o
);
  import vnoise2d_pkg::*;

  localparam int FRAC_SHIFT = Q_BITS - COORD_FRAC_BITS;

  // Handshake control
  logic [NUM_STAGES-1:0] valid_q, valid_d;
  logic [NUM_STAGES-1:0] adv;

  always_comb begin
    for (int k = 0; k < NUM_STAGES; k++) begin
      // A stage loads when the output moves or some stage at or after it is empty
      adv[k] = !out_stall_i ||
               !(&(valid_q | ~({NUM_STAGES{1'b1}} << k)));
    end
    for (int k = 0; k < NUM_STAGES; k++) begin
      if (k == 0) begin
        valid_d[k] = adv[k] ? in_valid_i : valid_q[k];
      end else begin
        valid_d[k] = adv[k] ? valid_q[k-1] : valid_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_stall_o  = !adv[0];
  assign out_valid_o = valid_q[NUM_STAGES-1];

  // Stage 1: lattice base, corner hash seeds, fractions
  logic [31:0]                  x0, y0, base;
  logic [NUM_CORNERS-1:0][31:0] seed;
  logic [NUM_CORNERS-1:0][31:0] n1_d, n1_q;
  logic [29:0]                  fx1_d, fy1_d, fx1_q, fy1_q;

  always_comb begin
    x0   = 32'(coord_x_i >>> COORD_FRAC_BITS);
    y0   = 32'(coord_y_i >>> COORD_FRAC_BITS);
    base = x0 + y0 * HASH_ROW_MUL;
    seed[C00] = base;
    seed[C10] = base + 32'd1;
    seed[C01] = base + HASH_ROW_MUL;
    seed[C11] = base + HASH_ROW_MUL + 32'd1;
    for (int i = 0; i < NUM_CORNERS; i++) begin
      n1_d[i] = (seed[i] << HASH_SHIFT) ^ seed[i];
    end
    fx1_d = 30'(coord_x_i[COORD_FRAC_BITS-1:0]) << FRAC_SHIFT;
    fy1_d = 30'(coord_y_i[COORD_FRAC_BITS-1:0]) << FRAC_SHIFT;
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      n1_q  <= n1_d;
      fx1_q <= fx1_d;
      fy1_q <= fy1_d;
    end
  end

  // Stage 2: n*n per corner, f*f per axis
  logic [NUM_CORNERS-1:0][31:0] n2_q, sq2_d, sq2_q;
  logic [29:0]                  fx2_q, fy2_q;
  logic [59:0]                  ffx2_d, ffy2_d, ffx2_q, ffy2_q;

  always_comb begin
    for (int i = 0; i < NUM_CORNERS; i++) begin
      sq2_d[i] = n1_q[i] * n1_q[i];
    end
    ffx2_d = 60'(fx1_q) * 60'(fx1_q);
    ffy2_d = 60'(fy1_q) * 60'(fy1_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      n2_q   <= n1_q;
      sq2_q  <= sq2_d;
      fx2_q  <= fx1_q;
      fy2_q  <= fy1_q;
      ffx2_q <= ffx2_d;
      ffy2_q <= ffy2_d;
    end
  end

  // Stage 3: inner hash polynomial, rounded f^2 and 3 - 2f
  logic [NUM_CORNERS-1:0][31:0] n3_q, t3_d, t3_q;
  logic [59:0]                  ffx_rnd, ffy_rnd;
  logic [29:0]                  f2x3_q, f2y3_q;
  logic [31:0]                  kx3_d, ky3_d, kx3_q, ky3_q;

  always_comb begin
    for (int i = 0; i < NUM_CORNERS; i++) begin
      t3_d[i] = sq2_q[i] * HASH_C1 + HASH_C2;
    end
    ffx_rnd = ffx2_q + HALF_Q30[59:0];
    ffy_rnd = ffy2_q + HALF_Q30[59:0];
    kx3_d   = THREE_Q30 - {1'b0, fx2_q, 1'b0};
    ky3_d   = THREE_Q30 - {1'b0, fy2_q, 1'b0};
  end

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      n3_q   <= n2_q;
      t3_q   <= t3_d;
      f2x3_q <= ffx_rnd[59:30];
      f2y3_q <= ffy_rnd[59:30];
      kx3_q  <= kx3_d;
      ky3_q  <= ky3_d;
    end
  end

  // Stage 4: outer hash product, smoothstep product
  logic [NUM_CORNERS-1:0][31:0] u4_d, u4_q;
  logic [61:0]                  px4_d, py4_d, px4_q, py4_q;

  always_comb begin
    for (int i = 0; i < NUM_CORNERS; i++) begin
      u4_d[i] = n3_q[i] * t3_q[i];
    end
    px4_d = 62'(f2x3_q) * 62'(kx3_q);
    py4_d = 62'(f2y3_q) * 62'(ky3_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      u4_q  <= u4_d;
      px4_q <= px4_d;
      py4_q <= py4_d;
    end
  end

  // Stage 5: corner values in Q2.30, clamped smoothstep weights
  logic [NUM_CORNERS-1:0][31:0] h5;
  value_t                       corner5_d [NUM_CORNERS];
  value_t                       corner5_q [NUM_CORNERS];
  logic [61:0]                  px_rnd, py_rnd;
  logic [30:0]                  sx5_d, sy5_d, sx5_q, sy5_q;

  always_comb begin
    for (int i = 0; i < NUM_CORNERS; i++) begin
      h5[i]        = {1'b0, 31'(u4_q[i] + HASH_C3)};
      corner5_d[i] = $signed(ONE_Q30 - h5[i]);
    end
    px_rnd = px4_q + HALF_Q30[61:0];
    py_rnd = py4_q + HALF_Q30[61:0];
    sx5_d  = (px_rnd[61:30] > ONE_Q30) ? ONE_Q30[30:0] : px_rnd[60:30];
    sy5_d  = (py_rnd[61:30] > ONE_Q30) ? ONE_Q30[30:0] : py_rnd[60:30];
  end

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      corner5_q <= corner5_d;
      sx5_q     <= sx5_d;
      sy5_q     <= sy5_d;
    end
  end

  // Stage 6: row differences
  logic signed [32:0] d06_d, d16_d, d06_q, d16_q;
  value_t             a06_q, a16_q;
  logic [30:0]        sx6_q, sy6_q;

  always_comb begin
    d06_d = 33'(corner5_q[C10]) - 33'(corner5_q[C00]);
    d16_d = 33'(corner5_q[C11]) - 33'(corner5_q[C01]);
  end

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      d06_q <= d06_d;
      d16_q <= d16_d;
      a06_q <= corner5_q[C00];
      a16_q <= corner5_q[C01];
      sx6_q <= sx5_q;
      sy6_q <= sy5_q;
    end
  end

  // Stage 7: row weight products
  logic signed [63:0] p07_d, p17_d, p07_q, p17_q;
  value_t             a07_q, a17_q;
  logic [30:0]        sy7_q;

  always_comb begin
    p07_d = d06_q * $signed({1'b0, sx6_q});
    p17_d = d16_q * $signed({1'b0, sx6_q});
  end

  always_ff @(posedge clk_i) begin
    if (adv[6]) begin
      p07_q <= p07_d;
      p17_q <= p17_d;
      a07_q <= a06_q;
      a17_q <= a16_q;
      sy7_q <= sy6_q;
    end
  end

  // Stage 8: row lerps, round half up
  logic signed [63:0] p07_rnd, p17_rnd;
  value_t             r08_d, r18_d, r08_q, r18_q;
  logic [30:0]        sy8_q;

  always_comb begin
    p07_rnd = (p07_q + $signed(HALF_Q30)) >>> Q_BITS;
    p17_rnd = (p17_q + $signed(HALF_Q30)) >>> Q_BITS;
    r08_d   = a07_q + p07_rnd[31:0];
    r18_d   = a17_q + p17_rnd[31:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv[7]) begin
      r08_q <= r08_d;
      r18_q <= r18_d;
      sy8_q <= sy7_q;
    end
  end

  // Stage 9: column difference
  logic signed [32:0] dr9_d, dr9_q;
  value_t             r09_q;
  logic [30:0]        sy9_q;

  assign dr9_d = 33'(r18_q) - 33'(r08_q);

  always_ff @(posedge clk_i) begin
    if (adv[8]) begin
      dr9_q <= dr9_d;
      r09_q <= r08_q;
      sy9_q <= sy8_q;
    end
  end

  // Stage 10: column weight product
  logic signed [63:0] pr10_d, pr10_q;
  value_t             r010_q;

  assign pr10_d = dr9_q * $signed({1'b0, sy9_q});

  always_ff @(posedge clk_i) begin
    if (adv[9]) begin
      pr10_q <= pr10_d;
      r010_q <= r09_q;
    end
  end

  // Stage 11: final lerp into the output register
  logic signed [63:0] pr_rnd;
  value_t             noise_d, noise_q;

  always_comb begin
    pr_rnd  = (pr10_q + $signed(HALF_Q30)) >>> Q_BITS;
    noise_d = r010_q + pr_rnd[31:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv[10]) begin
      noise_q <= noise_d;
    end
  end

  assign noise_value_o = noise_q;

  // Stall only when every stage holds an item
  a_stall_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&valid_q) && out_stall_i)
    else $error("input stalled while the pipeline has a bubble");

  a_weight_clamp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[4] |-> (sx5_q <= ONE_Q30[30:0]) && (sy5_q <= ONE_Q30[30:0]))
    else $error("smoothstep weight above one");

  a_corner_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[4] |-> (corner5_q[C00] <= $signed(ONE_Q30)) &&
                   (corner5_q[C10] <= $signed(ONE_Q30)) &&
                   (corner5_q[C01] <= $signed(ONE_Q30)) &&
                   (corner5_q[C11] <= $signed(ONE_Q30)))
    else $error("corner value above one");

  a_out_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (noise_value_o <= $signed(ONE_Q30)) &&
                    (noise_value_o >= -$signed(ONE_Q30 - 32'd1)))
    else $error("noise sample out of range");

endmodule
